>>> sv/plr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

    // Action codes carried by an input item.
    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_SETCODE = 2'd3;

    // Status codes returned with a result item.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Width of the slot index broadcast to the cells (covers up to 512 cells).
    localparam int SLOT_W = 9;

    // Width used for comparing a position against the length.
    localparam int CMP_W = 10;

    // One input item.
    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         position;
        logic signed [31:0] code_in;
        logic signed [15:0] row_in;
        logic signed [15:0] column_in;
        logic [31:0]        ident_in;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] code_out;
        logic signed [15:0] row_out;
        logic signed [15:0] column_out;
        logic [31:0]        ident_out;
        logic [5:0]         length_out;
    } result_t;

    // One stored record.
    typedef struct packed {
        logic signed [31:0] code;
        logic signed [15:0] row;
        logic signed [15:0] column;
        logic [31:0]        ident;
    } rec_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_SETCODE,
        OP_LOAD_TAP,
        OP_SHIFT_TAP
    } cell_op_t;

    // Control word shared by all cells.
    typedef struct packed {
        cell_op_t           op;
        logic [SLOT_W-1:0]  slot;
        rec_t               data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/positional_record_list_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY records held in a chain of cells, one record
// per cell. An item is accepted when start is high and busy is low. For
// insert, remove, set-code and any rejected item, the result is shown with
// done high for the single following cycle. A read loads every record into a
// tap chain and shifts it toward the first cell once per cycle, so a read at
// position p shows its result once record p has reached the first cell's
// tap, with busy high until that cycle. The receiver cannot stall: each
// result is valid for exactly the one cycle that done is high.
module positional_record_list_core #(
    parameter int CAPACITY = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire plr_pkg::cmd_t    cmd,
    output logic                  busy,
    output logic                  done,
    output plr_pkg::result_t      result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [5:0]          wait_reg;
    logic [5:0]          wait_next;
    logic                done_reg;
    logic                done_next;
    plr_pkg::result_t    result_reg;
    plr_pkg::result_t    result_next;

    plr_pkg::cell_ctrl_t ctrl;
    plr_pkg::rec_t       recs [CAPACITY];
    plr_pkg::rec_t       taps [CAPACITY];

    logic                accept;
    logic [5:0]          slot0;
    logic [plr_pkg::CMP_W-1:0] pos_ext;
    logic [plr_pkg::CMP_W-1:0] cnt_ext;
    logic                pos_ok_ins;
    logic                pos_ok;
    logic                full;
    logic [5:0]          length_now;

    assign accept     = start && (state_reg == S_IDLE);
    assign slot0      = cmd.position - 6'd1;
    assign pos_ext    = plr_pkg::CMP_W'(cmd.position);
    assign cnt_ext    = plr_pkg::CMP_W'(count_reg);
    assign pos_ok_ins = (cmd.position != 6'd0) && (pos_ext <= cnt_ext + 1'b1);
    assign pos_ok     = (cmd.position != 6'd0) && (pos_ext <= cnt_ext);
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign length_now = cnt_ext[5:0];

    // Control word broadcast to the cell chain.
    always_comb
    begin
        ctrl.op          = plr_pkg::OP_HOLD;
        ctrl.slot        = plr_pkg::SLOT_W'(slot0);
        ctrl.data.code   = cmd.code_in;
        ctrl.data.row    = cmd.row_in;
        ctrl.data.column = cmd.column_in;
        ctrl.data.ident  = cmd.ident_in;
        if (state_reg == S_READ)
        begin
            if (wait_reg != 6'd0)
            begin
                ctrl.op = plr_pkg::OP_SHIFT_TAP;
            end
        end
        else if (accept)
        begin
            case (cmd.action)
                plr_pkg::ACT_INSERT:
                begin
                    if (pos_ok_ins && !full)
                    begin
                        ctrl.op = plr_pkg::OP_INSERT;
                    end
                end
                plr_pkg::ACT_REMOVE:
                begin
                    if (pos_ok)
                    begin
                        ctrl.op = plr_pkg::OP_REMOVE;
                    end
                end
                plr_pkg::ACT_READ:
                begin
                    if (pos_ok)
                    begin
                        ctrl.op = plr_pkg::OP_LOAD_TAP;
                    end
                end
                plr_pkg::ACT_SETCODE:
                begin
                    if (pos_ok)
                    begin
                        ctrl.op = plr_pkg::OP_SETCODE;
                    end
                end
                default:
                begin
                    ctrl.op = plr_pkg::OP_HOLD;
                end
            endcase
        end
    end

    // The chain of cells; the first cell's tap carries read data out.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        plr_pkg::rec_t left_rec;
        plr_pkg::rec_t right_rec;
        plr_pkg::rec_t right_tap;

        if (i == 0)
        begin : g_first
            assign left_rec = ctrl.data;
        end
        else
        begin : g_mid_l
            assign left_rec = recs[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_rec = recs[i];
            assign right_tap = '0;
        end
        else
        begin : g_mid_r
            assign right_rec = recs[i+1];
            assign right_tap = taps[i+1];
        end

        plr_cell #(
            .INDEX(i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .left_rec (left_rec),
            .right_rec(right_rec),
            .right_tap(right_tap),
            .rec      (recs[i]),
            .tap      (taps[i])
        );
    end

    // Sequencer next state: length, read wait count and result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        wait_next   = wait_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next            = '0;
                    result_next.length_out = length_now;
                    done_next              = 1'b1;
                    case (cmd.action)
                        plr_pkg::ACT_INSERT:
                        begin
                            if (!pos_ok_ins)
                            begin
                                result_next.status = plr_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                result_next.status = plr_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next             = count_reg + 1'b1;
                                result_next.length_out = length_now + 6'd1;
                            end
                        end
                        plr_pkg::ACT_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                result_next.status = plr_pkg::ST_RANGE;
                            end
                            else
                            begin
                                count_next             = count_reg - 1'b1;
                                result_next.length_out = length_now - 6'd1;
                            end
                        end
                        plr_pkg::ACT_READ:
                        begin
                            if (!pos_ok)
                            begin
                                result_next.status = plr_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                wait_next  = slot0;
                                state_next = S_READ;
                            end
                        end
                        plr_pkg::ACT_SETCODE:
                        begin
                            if (!pos_ok)
                            begin
                                result_next.status = plr_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            result_next.status = plr_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (wait_reg == 6'd0)
                begin
                    result_next.status     = plr_pkg::ST_DONE;
                    result_next.code_out   = taps[0].code;
                    result_next.row_out    = taps[0].row;
                    result_next.column_out = taps[0].column;
                    result_next.ident_out  = taps[0].ident;
                    result_next.length_out = length_now;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    wait_next = wait_reg - 6'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            wait_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            wait_reg   <= wait_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg == S_READ);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> sv/plr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One list entry. It holds a record and a read tap, and trades both with
// its neighbors according to the broadcast control word.
module plr_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                clk,
    input  wire plr_pkg::cell_ctrl_t ctrl,
    input  wire plr_pkg::rec_t       left_rec,
    input  wire plr_pkg::rec_t       right_rec,
    input  wire plr_pkg::rec_t       right_tap,
    output plr_pkg::rec_t            rec,
    output plr_pkg::rec_t            tap
);

    localparam logic [plr_pkg::SLOT_W-1:0] ME = plr_pkg::SLOT_W'(INDEX);

    plr_pkg::rec_t rec_reg;
    plr_pkg::rec_t rec_next;
    plr_pkg::rec_t tap_reg;
    plr_pkg::rec_t tap_next;

    logic is_at;
    logic is_above;

    assign is_at    = (ctrl.slot == ME);
    assign is_above = (ME > ctrl.slot);

    // Next record and tap for the current operation.
    always_comb
    begin
        rec_next = rec_reg;
        tap_next = tap_reg;
        case (ctrl.op)
            plr_pkg::OP_INSERT:
            begin
                if (is_at)
                begin
                    rec_next = ctrl.data;
                end
                else if (is_above)
                begin
                    rec_next = left_rec;
                end
            end
            plr_pkg::OP_REMOVE:
            begin
                if (is_at || is_above)
                begin
                    rec_next = right_rec;
                end
            end
            plr_pkg::OP_SETCODE:
            begin
                if (is_at)
                begin
                    rec_next.code = ctrl.data.code;
                end
            end
            plr_pkg::OP_LOAD_TAP:
            begin
                tap_next = rec_reg;
            end
            plr_pkg::OP_SHIFT_TAP:
            begin
                tap_next = right_tap;
            end
            default:
            begin
                rec_next = rec_reg;
                tap_next = tap_reg;
            end
        endcase
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        tap_reg <= tap_next;
    end

    assign rec = rec_reg;
    assign tap = tap_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CAP = 32;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 138;
    localparam int CYCLE_LIMIT = 400000;
    // The settling time allows for the answer to a read at the deepest position.
    localparam int SETTLE_CYCLES = CAP + 8;

    // One row of the directed table; typed rows carry their own expected status and length.
    typedef struct {
        plr_pkg::cmd_t c;
        bit            typed;
        logic [1:0]    st;
        logic [5:0]    len;
    } step_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    plr_pkg::cmd_t    cmd = '0;
    logic             busy;
    logic             done;
    plr_pkg::result_t result;

    // Predicted contents of the list and its length.
    plr_pkg::rec_t    list_mem [CAP];
    int               list_len = 0;

    plr_pkg::result_t replies_due [$];
    int               error_count = 0;
    int               cycle_count = 0;
    step_t            directed [$];

    positional_record_list_core #(
        .CAPACITY(CAP)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Applies one action to the predicted list and returns the reply it should give.
    function automatic plr_pkg::result_t list_apply(input plr_pkg::cmd_t c);
        plr_pkg::result_t r;
        int               p;
        int               i;
        r = '0;
        p = int'(c.position);
        if (c.action == plr_pkg::ACT_INSERT)
        begin
            if (p < 1 || p > list_len + 1)
                r.status = plr_pkg::ST_RANGE;
            else if (list_len >= CAP)
                r.status = plr_pkg::ST_FULL;
            else
            begin
                for (i = list_len; i >= p; i--)
                    list_mem[i] = list_mem[i - 1];
                list_mem[p - 1] = '{c.code_in, c.row_in, c.column_in, c.ident_in};
                list_len++;
            end
        end
        else if (p < 1 || p > list_len)
            r.status = plr_pkg::ST_RANGE;
        else if (c.action == plr_pkg::ACT_REMOVE)
        begin
            for (i = p; i < list_len; i++)
                list_mem[i - 1] = list_mem[i];
            list_len--;
        end
        else if (c.action == plr_pkg::ACT_READ)
        begin
            r.code_out   = list_mem[p - 1].code;
            r.row_out    = list_mem[p - 1].row;
            r.column_out = list_mem[p - 1].column;
            r.ident_out  = list_mem[p - 1].ident;
        end
        else
            list_mem[p - 1].code = c.code_in;
        r.length_out = 6'(list_len);
        return r;
    endfunction

    function automatic step_t step(input logic [1:0] a, input logic [5:0] p,
                                   input logic [31:0] code, input logic [15:0] row,
                                   input logic [15:0] col, input logic [31:0] id,
                                   input bit typed, input logic [1:0] st,
                                   input logic [5:0] len);
        step_t s;
        s.c = '{a, p, code, row, col, id};
        s.typed = typed;
        s.st = st;
        s.len = len;
        return s;
    endfunction

    // Random action: mostly in-range positions, with the mix tilted to grow or shrink the list.
    function automatic plr_pkg::cmd_t make_cmd(input bit grow);
        plr_pkg::cmd_t c;
        int            r;
        int            top;
        r = $urandom_range(99);
        if (grow)
            c.action = (r < 55) ? plr_pkg::ACT_INSERT :
                       (r < 65) ? plr_pkg::ACT_REMOVE :
                       (r < 85) ? plr_pkg::ACT_READ : plr_pkg::ACT_SETCODE;
        else
            c.action = (r < 15) ? plr_pkg::ACT_INSERT :
                       (r < 55) ? plr_pkg::ACT_REMOVE :
                       (r < 80) ? plr_pkg::ACT_READ : plr_pkg::ACT_SETCODE;
        top = (c.action == plr_pkg::ACT_INSERT) ? list_len + 1 : list_len;
        if (top == 0 || $urandom_range(99) < 12)
            c.position = 6'($urandom_range(63));
        else
            c.position = 6'($urandom_range(top, 1));
        c.code_in   = $urandom;
        c.row_in    = 16'($urandom);
        c.column_in = 16'($urandom);
        c.ident_in  = $urandom;
        // Now and then use the code-only form, whatever the action.
        if ($urandom_range(9) == 0)
        begin
            c.row_in    = -16'sd2;
            c.column_in = -16'sd2;
            c.ident_in  = '0;
        end
        return c;
    endfunction

    // Presents one item after a random gap and returns at the edge that accepts it.
    task automatic send_item(input plr_pkg::cmd_t c, input int idle_pct);
        bit taken;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            if (!taken)
                @(negedge clk);
        end
    endtask

    // Holds the input quiet until every predicted reply has come back.
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, field, want, got);
        error_count++;
    endtask

    // Each strobed reply is checked against the oldest prediction.
    always @(posedge clk)
    begin
        plr_pkg::result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(result.status));
                if (result.code_out !== want.code_out)
                    report_mismatch("code_out", want.code_out, result.code_out);
                if (result.row_out !== want.row_out)
                    report_mismatch("row_out", 32'(want.row_out), 32'(result.row_out));
                if (result.column_out !== want.column_out)
                    report_mismatch("column_out", 32'(want.column_out),
                                    32'(result.column_out));
                if (result.ident_out !== want.ident_out)
                    report_mismatch("ident_out", want.ident_out, result.ident_out);
                if (result.length_out !== want.length_out)
                    report_mismatch("length_out", 32'(want.length_out),
                                    32'(result.length_out));
            end
        end
    end

    initial
    begin
        plr_pkg::result_t pred;
        plr_pkg::result_t typed_reply;
        plr_pkg::cmd_t    c;
        int               idle_pct [NUM_PHASES];

        idle_pct = '{0, 81, 0, 6, 81, 0, 6, 0};

        // Empty list: everything but an insert at position one is out of range.
        directed.push_back(step(plr_pkg::ACT_READ, 6'd1, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_REMOVE, 6'd1, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_SETCODE, 6'd0, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd0, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd2, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd0));
        // Field extremes, insert at the head, the tail and the middle, then reads and code updates.
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd1, 32'h7fffffff, 16'h7fff, 16'h8000,
                                32'hffffffff, 1'b1, plr_pkg::ST_DONE, 6'd1));
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd1, 32'h80000000, 16'h8000, 16'h7fff,
                                32'h0, 1'b1, plr_pkg::ST_DONE, 6'd2));
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd3, 32'h0, 16'hfffe, 16'hfffe, 32'h0,
                                1'b1, plr_pkg::ST_DONE, 6'd3));
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd2, 32'hffffffff, 16'hffff, 16'h0,
                                32'h80000000, 1'b1, plr_pkg::ST_DONE, 6'd4));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd1, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b0, plr_pkg::ST_DONE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd4, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b0, plr_pkg::ST_DONE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd2, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b0, plr_pkg::ST_DONE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd5, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd4));
        directed.push_back(step(plr_pkg::ACT_SETCODE, 6'd4, 32'h12345678, 16'd0, 16'd0,
                                32'd0, 1'b1, plr_pkg::ST_DONE, 6'd4));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd4, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b0, plr_pkg::ST_DONE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_SETCODE, 6'd5, 32'h1, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd4));
        // Remove from the head and from the tail, then reads, out-of-range items and an insert at the tail.
        directed.push_back(step(plr_pkg::ACT_REMOVE, 6'd1, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_DONE, 6'd3));
        directed.push_back(step(plr_pkg::ACT_REMOVE, 6'd3, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_DONE, 6'd2));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd1, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b0, plr_pkg::ST_DONE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd2, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b0, plr_pkg::ST_DONE, 6'd0));
        directed.push_back(step(plr_pkg::ACT_REMOVE, 6'd4, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd2));
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd63, 32'h1, 16'h1, 16'h1, 32'h1,
                                1'b1, plr_pkg::ST_RANGE, 6'd2));
        directed.push_back(step(plr_pkg::ACT_READ, 6'd63, 32'd0, 16'd0, 16'd0, 32'd0,
                                1'b1, plr_pkg::ST_RANGE, 6'd2));
        directed.push_back(step(plr_pkg::ACT_INSERT, 6'd3, 32'h55aa55aa, 16'h0123, 16'hfedc,
                                32'h5a5a5a5a, 1'b1, plr_pkg::ST_DONE, 6'd3));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; typed rows still run through the predictor to keep its list in step.
        foreach (directed[k])
        begin
            send_item(directed[k].c, 0);
            pred = list_apply(directed[k].c);
            if (directed[k].typed)
            begin
                typed_reply = '0;
                typed_reply.status = directed[k].st;
                typed_reply.length_out = directed[k].len;
                replies_due.push_back(typed_reply);
            end
            else
                replies_due.push_back(pred);
        end
        drain();

        // Random phases alternate between filling the list past full and emptying it.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                c = make_cmd(ph % 2 == 0);
                send_item(c, idle_pct[ph]);
                replies_due.push_back(list_apply(c));
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && replies_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
sv/plr_pkg.sv
sv/plr_cell.sv
sv/positional_record_list_core.sv
tb/sv/tb_top.sv
